// ----- design/ahcr_pkg.sv -----
package ahcr_pkg;

  localparam int PANEL_WIDTH_DEF = 14;
  localparam int ROWS            = 5;
  localparam int ANG_W           = 12;
  localparam int TAN_W           = 19;
  localparam int MAG_W           = 18;
  localparam int PL_W            = 12;
  localparam int COL_OUT_W       = 4;
  localparam int CHAR_W          = 8;
  localparam int FIFO_DEPTH      = 2;

  localparam int LINES_PER_CHAR  = 18;
  localparam int HALF_LINES      = 45;
  localparam int ALL_LINES       = 90;
  localparam int Q_SHIFT         = 12;

  localparam logic [38:0] RECIP_DIV10 = 39'd419431;
  localparam int          RECIP_SHIFT = 22;

  localparam logic [CHAR_W-1:0] GLYPH_LINE   = 8'h16;
  localparam logic [CHAR_W-1:0] GLYPH_TOP    = 8'h0e;
  localparam logic [CHAR_W-1:0] GLYPH_SIDE_L = 8'hb8;
  localparam logic [CHAR_W-1:0] GLYPH_SIDE_R = 8'hb9;
  localparam logic [CHAR_W-1:0] GLYPH_MID_L  = 8'hc8;
  localparam logic [CHAR_W-1:0] GLYPH_MID_R  = 8'hc9;
  localparam logic [CHAR_W-1:0] GLYPH_BLANK  = 8'h20;

  typedef struct packed {
    logic signed [TAN_W-1:0] tr;
    logic signed [PL_W-1:0]  pline;
  } att_t;

  // Tangent of whole degrees in Q12, saturated at 32.0.
  function automatic logic [MAG_W-1:0] tan_q12(input logic [6:0] idx);
    logic [MAG_W-1:0] v;
    unique case (idx)
      7'd0:  v = 18'd0;      7'd1:  v = 18'd71;     7'd2:  v = 18'd143;
      7'd3:  v = 18'd215;    7'd4:  v = 18'd286;    7'd5:  v = 18'd358;
      7'd6:  v = 18'd431;    7'd7:  v = 18'd503;    7'd8:  v = 18'd576;
      7'd9:  v = 18'd649;    7'd10: v = 18'd722;    7'd11: v = 18'd796;
      7'd12: v = 18'd871;    7'd13: v = 18'd946;    7'd14: v = 18'd1021;
      7'd15: v = 18'd1098;   7'd16: v = 18'd1175;   7'd17: v = 18'd1252;
      7'd18: v = 18'd1331;   7'd19: v = 18'd1410;   7'd20: v = 18'd1491;
      7'd21: v = 18'd1572;   7'd22: v = 18'd1655;   7'd23: v = 18'd1739;
      7'd24: v = 18'd1824;   7'd25: v = 18'd1910;   7'd26: v = 18'd1998;
      7'd27: v = 18'd2087;   7'd28: v = 18'd2178;   7'd29: v = 18'd2270;
      7'd30: v = 18'd2365;   7'd31: v = 18'd2461;   7'd32: v = 18'd2559;
      7'd33: v = 18'd2660;   7'd34: v = 18'd2763;   7'd35: v = 18'd2868;
      7'd36: v = 18'd2976;   7'd37: v = 18'd3087;   7'd38: v = 18'd3200;
      7'd39: v = 18'd3317;   7'd40: v = 18'd3437;   7'd41: v = 18'd3561;
      7'd42: v = 18'd3688;   7'd43: v = 18'd3820;   7'd44: v = 18'd3955;
      7'd45: v = 18'd4096;   7'd46: v = 18'd4242;   7'd47: v = 18'd4392;
      7'd48: v = 18'd4549;   7'd49: v = 18'd4712;   7'd50: v = 18'd4881;
      7'd51: v = 18'd5058;   7'd52: v = 18'd5243;   7'd53: v = 18'd5436;
      7'd54: v = 18'd5638;   7'd55: v = 18'd5850;   7'd56: v = 18'd6073;
      7'd57: v = 18'd6307;   7'd58: v = 18'd6555;   7'd59: v = 18'd6817;
      7'd60: v = 18'd7094;   7'd61: v = 18'd7389;   7'd62: v = 18'd7703;
      7'd63: v = 18'd8039;   7'd64: v = 18'd8398;   7'd65: v = 18'd8784;
      7'd66: v = 18'd9200;   7'd67: v = 18'd9650;   7'd68: v = 18'd10138;
      7'd69: v = 18'd10670;  7'd70: v = 18'd11254;  7'd71: v = 18'd11896;
      7'd72: v = 18'd12606;  7'd73: v = 18'd13397;  7'd74: v = 18'd14284;
      7'd75: v = 18'd15286;  7'd76: v = 18'd16428;  7'd77: v = 18'd17742;
      7'd78: v = 18'd19270;  7'd79: v = 18'd21072;  7'd80: v = 18'd23230;
      7'd81: v = 18'd25861;  7'd82: v = 18'd29145;  7'd83: v = 18'd33359;
      7'd84: v = 18'd38971;  7'd85: v = 18'd46817;  7'd86: v = 18'd58576;
      7'd87: v = 18'd78156;  7'd88: v = 18'd117294;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

// ----- design/ahcr_tan.sv -----
module ahcr_tan (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [ahcr_pkg::ANG_W-1:0]  angle,
  output logic signed [ahcr_pkg::TAN_W-1:0]  tan_q
);
  import ahcr_pkg::*;

  logic [13:0]      sx;
  logic [12:0]      x0;
  logic [10:0]      r0;
  logic             n0;
  logic [9:0]       m0;
  logic [9:0]       m1;
  logic             n1;
  logic [17:0]      dm;
  logic [6:0]       d1;
  logic [9:0]       d10;
  logic [9:0]       fr;
  logic [6:0]       d2;
  logic [3:0]       f2;
  logic             n2;
  logic [MAG_W-1:0] t0;
  logic [MAG_W-1:0] t1;
  logic [15:0]      diff;
  logic [19:0]      prod2;
  logic [MAG_W-1:0] t03;
  logic [19:0]      p3;
  logic             n3;
  logic [38:0]      qq;
  logic [TAN_W-1:0] mag;

  // Reduce the angle modulo 180 degrees and fold onto 0..90 degrees.
  always_comb begin
    sx = 14'({{2{angle[ANG_W-1]}}, angle}) + 14'd3600;
    x0 = sx[12:0];
    priority if (x0 >= 13'd5400) begin
      r0 = 11'(x0 - 13'd5400);
    end else if (x0 >= 13'd3600) begin
      r0 = 11'(x0 - 13'd3600);
    end else if (x0 >= 13'd1800) begin
      r0 = 11'(x0 - 13'd1800);
    end else begin
      r0 = x0[10:0];
    end
    n0 = (r0 > 11'd900);
    m0 = n0 ? 10'(11'd1800 - r0) : r0[9:0];
  end

  always_comb begin
    dm  = 18'(m1) * 18'd205;
    d1  = dm[17:11];
    d10 = 10'({d1, 3'b000}) + 10'({d1, 1'b0});
    fr  = m1 - d10;
  end

  always_comb begin
    t0    = tan_q12(d2);
    t1    = tan_q12(d2 + 7'd1);
    diff  = 16'(t1 - t0);
    prod2 = 20'(diff) * 20'(f2);
  end

  always_comb begin
    qq  = 39'(p3) * RECIP_DIV10;
    mag = 19'(t03) + 19'(qq[RECIP_SHIFT+15:RECIP_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1    <= m0;
      n1    <= n0;
      d2    <= d1;
      f2    <= fr[3:0];
      n2    <= n1;
      t03   <= t0;
      p3    <= prod2;
      n3    <= n2;
      tan_q <= n3 ? $signed(19'd0 - mag) : $signed(mag);
    end
  end

endmodule

// ----- design/ahcr_front.sv -----
module ahcr_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ahcr_pkg::ANG_W-1:0]  pitch_angle,
  input  logic signed [ahcr_pkg::ANG_W-1:0]  roll_angle,
  output logic                               att_valid,
  input  logic                               att_ready,
  output ahcr_pkg::att_t                     att
);
  import ahcr_pkg::*;

  logic                    adv;
  logic [3:0]              vpipe;
  logic signed [TAN_W-1:0] tp;
  logic signed [TAN_W-1:0] tr;
  logic [MAG_W-1:0]        ap;
  logic [23:0]             pm;
  logic [10:0]             pmag;
  logic signed [PL_W-1:0]  pline;

  assign adv      = !att_valid || att_ready;
  assign in_stall = !adv;

  ahcr_tan u_tan_pitch (.clk(clk), .en(adv), .angle(pitch_angle), .tan_q(tp));
  ahcr_tan u_tan_roll  (.clk(clk), .en(adv), .angle(roll_angle),  .tan_q(tr));

  always_comb begin
    ap    = tp[TAN_W-1] ? MAG_W'(-tp) : MAG_W'(tp);
    pm    = 24'(ap) * 24'd45;
    pmag  = pm[22:12];
    pline = tp[TAN_W-1] ? $signed(12'd0 - 12'(pmag)) : $signed(12'(pmag));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe     <= '0;
      att_valid <= 1'b0;
    end else if (adv) begin
      vpipe     <= {vpipe[2:0], in_valid};
      att_valid <= vpipe[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      att.tr    <= tr;
      att.pline <= pline;
    end
  end

endmodule

// ----- design/ahcr_fifo.sv -----
module ahcr_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  ahcr_pkg::att_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output ahcr_pkg::att_t pop_data
);
  import ahcr_pkg::*;

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  att_t            mem [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(FIFO_DEPTH - 1)) ? '0 : PtrW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(FIFO_DEPTH - 1)) ? '0 : PtrW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CntW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CntW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- design/ahcr_back.sv -----
module ahcr_back #(
  parameter int PANEL_WIDTH = ahcr_pkg::PANEL_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 att_valid,
  output logic                                 att_pop,
  input  ahcr_pkg::att_t                       att,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ahcr_pkg::COL_OUT_W-1:0]       column_index,
  output logic [ahcr_pkg::CHAR_W-1:0]          char_row0,
  output logic [ahcr_pkg::CHAR_W-1:0]          char_row1,
  output logic [ahcr_pkg::CHAR_W-1:0]          char_row2,
  output logic [ahcr_pkg::CHAR_W-1:0]          char_row3,
  output logic [ahcr_pkg::CHAR_W-1:0]          char_row4,
  output logic                                 last_column
);
  import ahcr_pkg::*;

  localparam int Inner  = PANEL_WIDTH - 2;
  localparam int MidOff = Inner * Inner / 2 + Inner / 2;
  localparam int CW     = $clog2(PANEL_WIDTH);
  localparam int MidW   = $clog2(Inner * Inner + 1) + 2;
  localparam int ProdW  = TAN_W + MidW;
  localparam int NumW   = ((ProdW > 25) ? ProdW : 25) + 1;
  localparam int HW     = NumW - 1 - Q_SHIFT;

  logic                    adv;
  logic                    issue;
  logic                    at_last;
  logic                    load;

  logic                    cur_valid;
  logic signed [TAN_W-1:0] cur_tr;
  logic signed [PL_W-1:0]  cur_pterm;
  logic [CW-1:0]           col;
  logic signed [MidW-1:0]  mid;

  logic                    a_valid;
  logic [CW-1:0]           a_col;
  logic signed [ProdW-1:0] a_prod;
  logic signed [PL_W-1:0]  a_pterm;
  logic                    a_border;
  logic                    a_left;
  logic                    a_last;

  logic signed [NumW-1:0]  num;
  logic [HW-1:0]           hitw;
  logic                    hit_ok;
  logic [6:0]              h1;
  logic [6:0]              rem;
  logic [2:0]              row;
  logic [3:0]              sub;
  logic [CW+3:0]           colx;
  logic [CHAR_W-1:0]       ch [ROWS];

  assign adv     = !out_valid || !out_stall;
  assign issue   = adv && cur_valid;
  assign at_last = (col == CW'(PANEL_WIDTH - 1));
  assign load    = adv && (!cur_valid || at_last);
  assign att_pop = load && att_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cur_valid <= att_valid;
      end
      if (adv) begin
        a_valid   <= issue;
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && att_valid) begin
      cur_tr    <= att.tr;
      cur_pterm <= att.pline + PL_W'(HALF_LINES);
      col       <= '0;
      mid       <= MidW'(-MidOff);
    end else if (issue) begin
      col <= CW'(col + 1'b1);
      mid <= mid + MidW'(Inner);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_col    <= col;
      a_prod   <= ProdW'(cur_tr) * ProdW'(mid);
      a_pterm  <= cur_pterm;
      a_border <= (col == '0) || at_last;
      a_left   <= (col == '0);
      a_last   <= at_last;
    end
  end

  always_comb begin
    num    = NumW'(a_prod) + (NumW'(a_pterm) <<< Q_SHIFT);
    hitw   = num[NumW-2:Q_SHIFT];
    hit_ok = !num[NumW-1] && (hitw != '0) && (hitw < HW'(ALL_LINES));
    h1     = hitw[6:0] - 7'd1;
    priority if (h1 >= 7'(4 * LINES_PER_CHAR)) begin
      row = 3'd0;
      rem = h1 - 7'(4 * LINES_PER_CHAR);
    end else if (h1 >= 7'(3 * LINES_PER_CHAR)) begin
      row = 3'd1;
      rem = h1 - 7'(3 * LINES_PER_CHAR);
    end else if (h1 >= 7'(2 * LINES_PER_CHAR)) begin
      row = 3'd2;
      rem = h1 - 7'(2 * LINES_PER_CHAR);
    end else if (h1 >= 7'(LINES_PER_CHAR)) begin
      row = 3'd3;
      rem = h1 - 7'(LINES_PER_CHAR);
    end else begin
      row = 3'd4;
      rem = h1;
    end
    sub = rem[4:1];
    for (int k = 0; k < ROWS; k++) begin
      if (a_border) begin
        ch[k] = a_left ? GLYPH_SIDE_L : GLYPH_SIDE_R;
        if (k == ROWS / 2) begin
          ch[k] = a_left ? GLYPH_MID_L : GLYPH_MID_R;
        end
      end else if (hit_ok && (3'(k) == row)) begin
        ch[k] = GLYPH_LINE + CHAR_W'(sub);
      end else if (hit_ok && (sub == 4'd8) && (3'(k + 1) == row)) begin
        // The top glyph sits in the row above; on the top row it is dropped.
        ch[k] = GLYPH_TOP;
      end else begin
        ch[k] = GLYPH_BLANK;
      end
    end
    colx = {4'b0000, a_col};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      column_index <= colx[COL_OUT_W-1:0];
      char_row0    <= ch[0];
      char_row1    <= ch[1];
      char_row2    <= ch[2];
      char_row3    <= ch[3];
      char_row4    <= ch[4];
      last_column  <= a_last;
    end
  end

endmodule

// ----- design/artificial_horizon_column_render_unit.sv -----
// Artificial horizon panel renderer.
// Input channel (in_valid/in_stall): one beat carries a pitch and a roll angle in
// tenths of a degree. Output channel (out_valid/out_stall): one beat per panel
// column, left to right, PANEL_WIDTH beats per input beat, each with the column
// index, the five character codes from top to bottom and a flag on the last one.
// The front end computes both tangents and the pitch line in a five-stage pipeline
// and may take a new input beat every cycle while its queue has room. The back end
// steps through the columns, one per cycle unless the receiver stalls, through a
// multiply stage and an output register. Its column sequencer takes a new input
// beat only when idle or as it issues the last column of the current one.
// Reset clears every valid flag and the queue; no beat is pending afterwards.
// When the receiver stalls, the output beat holds; the back end and then the queue
// fill, and in_stall rises only once the front pipeline has nowhere to go.
module artificial_horizon_column_render_unit #(
  parameter int PANEL_WIDTH = ahcr_pkg::PANEL_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ahcr_pkg::ANG_W-1:0]   pitch_angle,
  input  logic signed [ahcr_pkg::ANG_W-1:0]   roll_angle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ahcr_pkg::COL_OUT_W-1:0]      column_index,
  output logic [ahcr_pkg::CHAR_W-1:0]         char_row0,
  output logic [ahcr_pkg::CHAR_W-1:0]         char_row1,
  output logic [ahcr_pkg::CHAR_W-1:0]         char_row2,
  output logic [ahcr_pkg::CHAR_W-1:0]         char_row3,
  output logic [ahcr_pkg::CHAR_W-1:0]         char_row4,
  output logic                                last_column
);
  import ahcr_pkg::*;

  logic fr_valid;
  logic fr_ready;
  att_t fr_att;
  logic q_valid;
  logic q_pop;
  att_t q_att;

  ahcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pitch_angle(pitch_angle),
    .roll_angle (roll_angle),
    .att_valid  (fr_valid),
    .att_ready  (fr_ready),
    .att        (fr_att)
  );

  ahcr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_data (fr_att),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_att)
  );

  ahcr_back #(
    .PANEL_WIDTH(PANEL_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .att_valid   (q_valid),
    .att_pop     (q_pop),
    .att         (q_att),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .column_index(column_index),
    .char_row0   (char_row0),
    .char_row1   (char_row1),
    .char_row2   (char_row2),
    .char_row3   (char_row3),
    .char_row4   (char_row4),
    .last_column (last_column)
  );

endmodule

// ----- design/ahcr_checker.sv -----
module ahcr_checker #(
  parameter int PANEL_WIDTH = ahcr_pkg::PANEL_WIDTH_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ahcr_pkg::COL_OUT_W-1:0]  column_index,
  input logic [ahcr_pkg::CHAR_W-1:0]     char_row0,
  input logic [ahcr_pkg::CHAR_W-1:0]     char_row2,
  input logic                            last_column
);
  import ahcr_pkg::*;

  localparam logic [COL_OUT_W-1:0] LastIdx = COL_OUT_W'(PANEL_WIDTH - 1);

  // Nothing is pending once reset has been applied.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(column_index) && $stable(char_row2))
    else $error("stalled output beat changed");

  // The last column is the right-hand border.
  a_last_border: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_column |-> column_index == LastIdx && char_row2 == GLYPH_MID_R
                                 && char_row0 == GLYPH_SIDE_R)
    else $error("last column is not the right border");

  // Columns of one panel come in order.
  a_column_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_column |=>
      !out_valid || column_index == COL_OUT_W'($past(column_index) + 4'd1))
    else $error("column sequence broken");

endmodule

bind artificial_horizon_column_render_unit ahcr_checker #(
  .PANEL_WIDTH(PANEL_WIDTH)
) u_ahcr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .column_index(column_index),
  .char_row0   (char_row0),
  .char_row2   (char_row2),
  .last_column (last_column)
);

// ----- tb/horizon_tb_pkg.sv -----
`timescale 1ns / 100ps
package horizon_tb_pkg;

  localparam int PANEL_COLUMNS = 14;
  localparam int PANEL_ROWS    = 5;
  localparam int INNER_COLUMNS = PANEL_COLUMNS - 2;
  localparam int Q12_ONE       = 4096;
  localparam int CENTRE_LINE   = 45;
  localparam int LINE_SPAN     = 90;
  localparam int LINES_IN_CHAR = 18;
  localparam int SUB_STEPS     = 9;

  localparam logic [ahcr_pkg::CHAR_W-1:0] CH_LINE   = 8'h16;
  localparam logic [ahcr_pkg::CHAR_W-1:0] CH_TOP    = 8'h0e;
  localparam logic [ahcr_pkg::CHAR_W-1:0] CH_EDGE_L = 8'hb8;
  localparam logic [ahcr_pkg::CHAR_W-1:0] CH_EDGE_R = 8'hb9;
  localparam logic [ahcr_pkg::CHAR_W-1:0] CH_MID_L  = 8'hc8;
  localparam logic [ahcr_pkg::CHAR_W-1:0] CH_MID_R  = 8'hc9;
  localparam logic [ahcr_pkg::CHAR_W-1:0] CH_BLANK  = 8'h20;

  localparam int TAN_DEG_Q12 [0:90] = '{
    0, 71, 143, 215, 286, 358, 431, 503, 576, 649,
    722, 796, 871, 946, 1021, 1098, 1175, 1252, 1331, 1410,
    1491, 1572, 1655, 1739, 1824, 1910, 1998, 2087, 2178, 2270,
    2365, 2461, 2559, 2660, 2763, 2868, 2976, 3087, 3200, 3317,
    3437, 3561, 3688, 3820, 3955, 4096, 4242, 4392, 4549, 4712,
    4881, 5058, 5243, 5436, 5638, 5850, 6073, 6307, 6555, 6817,
    7094, 7389, 7703, 8039, 8398, 8784, 9200, 9650, 10138, 10670,
    11254, 11896, 12606, 13397, 14284, 15286, 16428, 17742, 19270, 21072,
    23230, 25861, 29145, 33359, 38971, 46817, 58576, 78156, 117294, 131072,
    131072
  };

  typedef struct packed {
    logic [ahcr_pkg::COL_OUT_W-1:0]                  column;
    logic [PANEL_ROWS-1:0][ahcr_pkg::CHAR_W-1:0]     rows;
    logic                                            last;
  } column_beat_t;

  // Tangent in Q12 of an angle in tenths of a degree, folded into (-90, 90].
  function automatic int tan_of_tenths(int angle);
    int wrapped, mag, deg, frac, t;
    wrapped = (angle + 3600) % 1800;
    mag = (wrapped > 900) ? 1800 - wrapped : wrapped;
    deg = mag / 10;
    frac = mag % 10;
    if (deg >= 90) begin
      t = TAN_DEG_Q12[90];
    end else begin
      t = TAN_DEG_Q12[deg] + ((TAN_DEG_Q12[deg + 1] - TAN_DEG_Q12[deg]) * frac) / 10;
    end
    return (wrapped > 900) ? -t : t;
  endfunction

  class horizon_scoreboard;
    column_beat_t expected_columns[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_columns.size();
    endfunction

    function void note_attitude(int pitch, int roll);
      int tan_pitch, tan_roll, pitch_mag, level_offset, middle, h1, row, sub;
      longint line_pos, hit;
      column_beat_t beat;
      tan_pitch = tan_of_tenths(pitch);
      tan_roll = tan_of_tenths(roll);
      pitch_mag = ((tan_pitch < 0) ? -tan_pitch : tan_pitch) * CENTRE_LINE / Q12_ONE;
      level_offset = (tan_pitch < 0) ? -pitch_mag : pitch_mag;
      for (int col = 0; col < PANEL_COLUMNS; col++) begin
        if (col == 0 || col == PANEL_COLUMNS - 1) begin
          for (int k = 0; k < PANEL_ROWS; k++) begin
            beat.rows[k] = (col == 0) ? CH_EDGE_L : CH_EDGE_R;
          end
          beat.rows[PANEL_ROWS / 2] = (col == 0) ? CH_MID_L : CH_MID_R;
        end else begin
          for (int k = 0; k < PANEL_ROWS; k++) begin
            beat.rows[k] = CH_BLANK;
          end
          middle = col * INNER_COLUMNS - (INNER_COLUMNS * INNER_COLUMNS) / 2
                   - INNER_COLUMNS / 2;
          line_pos = longint'(tan_roll) * middle
                     + longint'(level_offset + CENTRE_LINE) * Q12_ONE;
          if (line_pos >= Q12_ONE) begin
            hit = line_pos / Q12_ONE;
            if (hit < LINE_SPAN) begin
              h1 = int'(hit) - 1;
              row = (PANEL_ROWS - 1) - h1 / LINES_IN_CHAR;
              sub = ((h1 % LINES_IN_CHAR) * SUB_STEPS) / LINES_IN_CHAR;
              if (sub == SUB_STEPS - 1 && row >= 1) begin
                beat.rows[row - 1] = CH_TOP;
              end
              beat.rows[row] = CH_LINE + 8'(sub);
            end
          end
        end
        beat.column = 4'(col);
        beat.last = (col == PANEL_COLUMNS - 1);
        expected_columns.push_back(beat);
      end
    endfunction

    function void check_column(column_beat_t seen);
      column_beat_t want;
      if (expected_columns.size() == 0) begin
        $error("column beat with nothing expected: column_index %0d", seen.column);
        errors++;
        return;
      end
      want = expected_columns.pop_front();
      if (seen.column !== want.column) begin
        $error("column_index: expected %0d, got %0d", want.column, seen.column);
        errors++;
      end
      for (int k = 0; k < PANEL_ROWS; k++) begin
        if (seen.rows[k] !== want.rows[k]) begin
          $error("char_row%0d: expected 0x%02h, got 0x%02h", k, want.rows[k],
                 seen.rows[k]);
          errors++;
        end
      end
      if (seen.last !== want.last) begin
        $error("last_column: expected %0b, got %0b", want.last, seen.last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import horizon_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ahcr_pkg::ANG_W-1:0] pitch_angle = '0;
  logic signed [ahcr_pkg::ANG_W-1:0] roll_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ahcr_pkg::COL_OUT_W-1:0] column_index;
  logic [ahcr_pkg::CHAR_W-1:0] char_row0;
  logic [ahcr_pkg::CHAR_W-1:0] char_row1;
  logic [ahcr_pkg::CHAR_W-1:0] char_row2;
  logic [ahcr_pkg::CHAR_W-1:0] char_row3;
  logic [ahcr_pkg::CHAR_W-1:0] char_row4;
  logic last_column;

  horizon_scoreboard panel_sb = new();
  int long_hold = 0;
  bit quiet = 1'b0;

  artificial_horizon_column_render_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    column_beat_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.column = column_index;
      seen.rows[0] = char_row0;
      seen.rows[1] = char_row1;
      seen.rows[2] = char_row2;
      seen.rows[3] = char_row3;
      seen.rows[4] = char_row4;
      seen.last = last_column;
      panel_sb.check_column(seen);
    end
  end

  // A long hold requested by the main sequence is counted down here.
  initial begin
    int gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        long_hold--;
      end else if (gap_left > 0) begin
        out_stall <= 1'b1;
        gap_left--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 11);
      end
    end
  end

  task automatic send_attitude(input int pitch, input int roll);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pitch_angle <= 12'(pitch);
    roll_angle <= 12'(roll);
    do @(posedge clk); while (in_stall);
    panel_sb.note_attitude(pitch, roll);
  endtask

  task automatic send_random_attitude();
    int pitch, roll;
    if ($urandom_range(0, 3) == 0) begin
      pitch = int'($urandom_range(0, 4095)) - 2048;
      roll = int'($urandom_range(0, 4095)) - 2048;
    end else begin
      pitch = int'($urandom_range(0, 900)) - 450;
      roll = int'($urandom_range(0, 1200)) - 600;
    end
    send_attitude(pitch, roll);
  endtask

  task automatic drain_panels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (panel_sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_attitude(0, 0);
    send_attitude(1800, 0);
    send_attitude(-1800, 0);
    send_attitude(2047, 0);
    send_attitude(-2048, 0);
    send_attitude(0, 2047);
    send_attitude(0, -2048);
    send_attitude(900, 0);
    send_attitude(-900, 0);
    send_attitude(0, 900);
    send_attitude(0, -900);
    send_attitude(444, 0);
    send_attitude(-320, 0);
    send_attitude(100, 150);
    send_attitude(-250, -300);
    send_attitude(0, 450);
    send_attitude(0, -450);
    send_attitude(1900, -1900);
    send_attitude(450, 1);
    send_attitude(-1, -1);
    send_attitude(899, 901);
    send_attitude(-2048, 2047);
    send_attitude(1350, -1350);

    for (int n = 0; n < 100; n++) send_random_attitude();

    long_hold = 300;
    for (int n = 0; n < 40; n++) send_random_attitude();
    drain_panels();

    for (int n = 0; n < 70; n++) send_random_attitude();

    quiet = 1'b1;
    for (int n = 0; n < 40; n++) send_random_attitude();

    drain_panels();
    repeat (30) @(posedge clk);
    if (panel_sb.errors == 0 && panel_sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ahcr_pkg.sv
design/ahcr_tan.sv
design/ahcr_front.sv
design/ahcr_fifo.sv
design/ahcr_back.sv
design/artificial_horizon_column_render_unit.sv
design/ahcr_checker.sv
tb/horizon_tb_pkg.sv
tb/tb_top.sv
